[rtl/core/fmrd_pkg.sv]
`default_nettype none
package fmrd_pkg;

	localparam logic [7:0] HDR_BYTE0 = 8'hEF;
	localparam logic [7:0] HDR_BYTE1 = 8'h01;

	localparam logic [15:0] MIN_LENGTH = 16'd3;

	localparam logic [31:0] MODULE_ADDRESS_RESET = 32'hFFFF_FFFF;
	localparam logic [15:0] MAX_LENGTH_RESET = 16'd118;

	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// register indexes as seen on paddr[2]
	localparam logic REG_MODULE_ADDRESS = 1'b0;
	localparam logic REG_MAX_LENGTH = 1'b1;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// status codes
	localparam logic [2:0] STATUS_OK = 3'd0;
	localparam logic [2:0] STATUS_BAD_HEADER = 3'd1;
	localparam logic [2:0] STATUS_BAD_ADDRESS = 3'd2;
	localparam logic [2:0] STATUS_BAD_LENGTH = 3'd3;
	localparam logic [2:0] STATUS_BAD_CHECKSUM = 3'd4;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} rx_beat_t;

	typedef struct packed {
		logic        item_kind;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		logic [2:0]  status;
		logic [7:0]  confirm_code;
		logic        frame_last;
	} res_beat_t;

	function automatic res_beat_t make_status(input logic [2:0] st, input logic [7:0] code);
		res_beat_t r;
		r.item_kind = KIND_STATUS;
		r.payload_byte = 8'h00;
		r.payload_index = 16'h0000;
		r.status = st;
		r.confirm_code = (st == STATUS_OK) ? code : 8'h00;
		r.frame_last = 1'b1;
		return r;
	endfunction

	function automatic res_beat_t make_payload(input logic [7:0] b, input logic [15:0] idx);
		res_beat_t r;
		r.item_kind = KIND_PAYLOAD;
		r.payload_byte = b;
		r.payload_index = idx;
		r.status = STATUS_OK;
		r.confirm_code = 8'h00;
		r.frame_last = 1'b0;
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/core/fmrd_front.sv]
`default_nettype none
module fmrd_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      rx_valid,
	output logic                     rx_stall,
	input  fmrd_pkg::rx_beat_t       rx_beat,
	input  wire  [31:0]              module_address,
	input  wire  [15:0]              max_length,
	input  wire                      queue_full,
	output logic                     push,
	output fmrd_pkg::res_beat_t      push_beat
);
	import fmrd_pkg::*;

	logic [15:0] pos_q, len_q, sum_q;
	logic [7:0]  chi_q, conf_q;
	logic        disc_q;

	logic [15:0] pos_e, len_e, sum_e;
	logic [7:0]  chi_e, conf_e;
	logic        disc_e;

	logic [15:0] pos_n, len_n, sum_n;
	logic [7:0]  chi_n, conf_n;
	logic        disc_n;

	logic        accept;
	logic        has_result;
	res_beat_t   result;

	logic [7:0]  b;
	logic [15:0] sum_add;
	logic [15:0] hdr_len;
	logic [16:0] pos_p2;
	logic [16:0] len_ext;
	logic [7:0]  addr_byte;

	assign rx_stall = queue_full;
	assign accept = rx_valid && !queue_full;
	assign b = rx_beat.rx_byte;

	// a start byte restarts the parser before it is looked at
	always_comb begin
		if (rx_beat.frame_start) begin
			pos_e = 16'h0000;
			len_e = 16'h0000;
			sum_e = 16'h0000;
			chi_e = 8'h00;
			conf_e = 8'h00;
			disc_e = 1'b0;
		end else begin
			pos_e = pos_q;
			len_e = len_q;
			sum_e = sum_q;
			chi_e = chi_q;
			conf_e = conf_q;
			disc_e = disc_q;
		end
	end

	assign sum_add = sum_e + {8'h00, b};
	assign hdr_len = {chi_e, b};
	assign pos_p2 = {1'b0, pos_e} + 17'd2;
	assign len_ext = {1'b0, len_e};

	always_comb begin
		unique case (pos_e[2:0])
			3'd2:    addr_byte = module_address[31:24];
			3'd3:    addr_byte = module_address[23:16];
			3'd4:    addr_byte = module_address[15:8];
			default: addr_byte = module_address[7:0];
		endcase
	end

	always_comb begin
		pos_n = pos_e;
		len_n = len_e;
		sum_n = sum_e;
		chi_n = chi_e;
		conf_n = conf_e;
		disc_n = disc_e;
		has_result = 1'b0;
		result = make_payload(8'h00, 16'h0000);
		if (!disc_e) begin
			if (len_e == 16'h0000) begin
				// header
				pos_n = pos_e + 16'd1;
				priority if (pos_e == 16'd0) begin
					if (b != HDR_BYTE0) begin
						has_result = 1'b1;
						result = make_status(STATUS_BAD_HEADER, 8'h00);
					end
				end else if (pos_e == 16'd1) begin
					if (b != HDR_BYTE1) begin
						has_result = 1'b1;
						result = make_status(STATUS_BAD_HEADER, 8'h00);
					end
				end else if (pos_e <= 16'd5) begin
					if (b != addr_byte) begin
						has_result = 1'b1;
						result = make_status(STATUS_BAD_ADDRESS, 8'h00);
					end
				end else if (pos_e == 16'd6) begin
					sum_n = sum_add;
				end else if (pos_e == 16'd7) begin
					chi_n = b;
					sum_n = sum_add;
				end else begin
					sum_n = sum_add;
					if (hdr_len < MIN_LENGTH || hdr_len > max_length) begin
						has_result = 1'b1;
						result = make_status(STATUS_BAD_LENGTH, 8'h00);
					end else begin
						len_n = hdr_len;
						pos_n = 16'h0000;
					end
				end
			end else begin
				// body
				pos_n = pos_e + 16'd1;
				priority if (pos_e == 16'd0) begin
					conf_n = b;
					sum_n = sum_add;
				end else if (pos_p2 < len_ext) begin
					sum_n = sum_add;
					has_result = 1'b1;
					result = make_payload(b, pos_e - 16'd1);
				end else if (pos_p2 == len_ext) begin
					chi_n = b;
				end else begin
					has_result = 1'b1;
					if ({chi_e, b} == sum_e)
						result = make_status(STATUS_OK, conf_e);
					else
						result = make_status(STATUS_BAD_CHECKSUM, 8'h00);
				end
			end
			if (has_result && result.frame_last)
				disc_n = 1'b1;
		end
	end

	assign push = accept && has_result;
	assign push_beat = result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 16'h0000;
			len_q <= 16'h0000;
			sum_q <= 16'h0000;
			chi_q <= 8'h00;
			conf_q <= 8'h00;
			disc_q <= 1'b1;
		end else if (accept) begin
			pos_q <= pos_n;
			len_q <= len_n;
			sum_q <= sum_n;
			chi_q <= chi_n;
			conf_q <= conf_n;
			disc_q <= disc_n;
		end
	end

endmodule
`default_nettype wire

[rtl/core/fmrd_queue.sv]
`default_nettype none
module fmrd_queue #(
	parameter int DEPTH = fmrd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  fmrd_pkg::res_beat_t  push_beat,
	output logic                 full,
	output logic                 not_empty,
	input  wire                  pop,
	output fmrd_pkg::res_beat_t  head_beat
);
	import fmrd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	res_beat_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign head_beat = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

[rtl/core/fmrd_back.sv]
`default_nettype none
module fmrd_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  head_valid,
	input  fmrd_pkg::res_beat_t  head_beat,
	output logic                 pop,
	output logic                 res_valid,
	input  wire                  res_stall,
	output fmrd_pkg::res_beat_t  res_beat
);
	import fmrd_pkg::*;

	logic      valid_q;
	res_beat_t beat_q;

	// refill the output register when it is empty or being taken
	assign pop = head_valid && (!valid_q || !res_stall);
	assign res_valid = valid_q;
	assign res_beat = beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !res_stall) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			beat_q <= head_beat;
	end

endmodule
`default_nettype wire

[rtl/core/fingerprint_module_reply_deframer.sv]
`default_nettype none
// path: a result beat goes through the result queue and then the output register to res_beat
// throughput: one byte per cycle while rx_stall is low; the parser updates its state once per byte
// rx_stall rises only when the result queue is full, i.e. when res_stall has held off the output
// reset: parser discards bytes until a frame start, queue and output register empty,
// module_address = 0xFFFFFFFF and max_length = 118
module fingerprint_module_reply_deframer #(
	parameter int QUEUE_DEPTH = fmrd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire                  clk,
	input  wire                  arst_n,
	// byte input channel
	input  wire                  rx_valid,
	output logic                 rx_stall,
	input  fmrd_pkg::rx_beat_t   rx_beat,
	// result channel
	output logic                 res_valid,
	input  wire                  res_stall,
	output fmrd_pkg::res_beat_t  res_beat,
	// register port
	input  wire                  psel,
	input  wire                  penable,
	input  wire                  pwrite,
	input  wire  [2:0]           paddr,
	input  wire  [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import fmrd_pkg::*;

	logic [31:0] module_address_q;
	logic [15:0] max_length_q;
	logic        reg_write;

	logic        queue_full;
	logic        queue_not_empty;
	logic        push;
	logic        pop;
	res_beat_t   push_beat;
	res_beat_t   head_beat;

	// register port: zero wait states, register selected by address bit 2
	assign pready = 1'b1;
	assign reg_write = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_MODULE_ADDRESS: prdata = module_address_q;
			default:            prdata = {16'h0000, max_length_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_address_q <= MODULE_ADDRESS_RESET;
			max_length_q <= MAX_LENGTH_RESET;
		end else if (reg_write) begin
			if (paddr[2] == REG_MODULE_ADDRESS)
				module_address_q <= pwdata;
			else
				max_length_q <= pwdata[15:0];
		end
	end

	// front: parses each byte, checks header, address, length and checksum,
	// and pushes payload bytes and the final status into the queue
	fmrd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx_valid       (rx_valid),
		.rx_stall       (rx_stall),
		.rx_beat        (rx_beat),
		.module_address (module_address_q),
		.max_length     (max_length_q),
		.queue_full     (queue_full),
		.push           (push),
		.push_beat      (push_beat)
	);

	// short queue so the parser keeps going while the output is held off
	fmrd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_beat (push_beat),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.pop       (pop),
		.head_beat (head_beat)
	);

	// back: output register that presents result beats
	fmrd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (queue_not_empty),
		.head_beat  (head_beat),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_beat   (res_beat)
	);

endmodule
`default_nettype wire
